@@ rtl/hctb_pkg.sv @@
package hctb_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int CODE_BYTES  = 4;
    localparam int FREQ_BITS   = 24;

    localparam int MAX_BITS  = 8 * CODE_BYTES;
    localparam int IDX_W     = $clog2(MAX_SYMBOLS);
    localparam int CNT_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int ID_W      = 9;
    localparam int NODE_BASE = 256;
    localparam int WEIGHT_W  = 32;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_FEW   = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_NOT_READY = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } t_wl_entry;

    typedef struct packed {
        logic [ID_W-1:0] lo_id;
        logic [ID_W-1:0] nx_id;
    } t_tree_node;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_node_code;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_leaf_entry;

endpackage

@@ rtl/huffman_code_table_builder_top.sv @@
// a load without last_pair answers in the cycle after acceptance; a read that finds its
// entry answers through the S_READ state and then the result slot, any other read in the
// cycle after acceptance; a load with last_pair and at least two stored pairs runs the
// build, an insertion sort and then merge scan/shift loops that step through the weight
// list memory one entry at a time
// throughput: one transaction at a time; the next is taken once the result slot is free
// reset: synchronous active low, clears control state only; memories are not cleared
module huffman_code_table_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_symbol,
    input  logic [23:0] i_frequency,
    input  logic        i_last_pair,
    input  logic [7:0]  i_entry_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_symbol,
    output logic [31:0] o_code_word,
    output logic [5:0]  o_code_length,
    output logic        o_final_entry
);
    import hctb_pkg::*;

    // sequencer state codes
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SORT_RD   = 5'd1;
    localparam logic [4:0] S_SORT_GET  = 5'd2;
    localparam logic [4:0] S_SORT_CMP  = 5'd3;
    localparam logic [4:0] S_SORT_PUT  = 5'd4;
    localparam logic [4:0] S_MRG_LO    = 5'd5;
    localparam logic [4:0] S_MRG_NX    = 5'd6;
    localparam logic [4:0] S_MRG_SUM   = 5'd7;
    localparam logic [4:0] S_MRG_SCAN  = 5'd8;
    localparam logic [4:0] S_MRG_SH    = 5'd9;
    localparam logic [4:0] S_MRG_SH_WR = 5'd10;
    localparam logic [4:0] S_CODE_INIT = 5'd11;
    localparam logic [4:0] S_CODE_RD   = 5'd12;
    localparam logic [4:0] S_CODE_A    = 5'd13;
    localparam logic [4:0] S_CODE_B    = 5'd14;
    localparam logic [4:0] S_READ      = 5'd15;

    // memories: weight list, merged tree nodes, code of each inner node, leaf table
    t_wl_entry   r_wl_mem   [MAX_SYMBOLS];
    t_tree_node  r_tn_mem   [MAX_SYMBOLS-1];
    t_node_code  r_nc_mem   [MAX_SYMBOLS-1];
    t_leaf_entry r_leaf_mem [MAX_SYMBOLS];

    t_wl_entry   r_wl_rd;
    t_tree_node  r_tn_rd;
    t_node_code  r_nc_rd;
    t_leaf_entry r_leaf_rd;

    logic             wl_we;
    logic [IDX_W-1:0] wl_waddr;
    t_wl_entry        wl_wdata;
    logic [IDX_W-1:0] wl_raddr;
    logic             tn_we;
    logic [IDX_W-1:0] tn_waddr;
    t_tree_node       tn_wdata;
    logic             nc_we;
    logic [IDX_W-1:0] nc_waddr;
    t_node_code       nc_wdata;
    logic             leaf_we;
    logic [IDX_W-1:0] leaf_waddr;
    t_leaf_entry      leaf_wdata;
    logic [IDX_W-1:0] leaf_raddr;

    // control registers
    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_pc, n_pc;
    logic             r_ready, n_ready;
    logic [2:0]       r_err, n_err;
    logic [2:0]       r_lstat, n_lstat;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_p, n_p;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_t, n_t;
    logic [CNT_W-1:0] r_leaf_cnt, n_leaf_cnt;
    logic [IDX_W-1:0] r_ridx, n_ridx;
    t_wl_entry        r_e, n_e;
    t_wl_entry        r_lo, n_lo;
    logic [WEIGHT_W-1:0] r_sum, n_sum;
    logic [ID_W-1:0]  r_c2_id, n_c2_id;
    t_node_code       r_c2, n_c2;

    // result slot
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_osym, n_osym;
    logic [31:0] r_code, n_code;
    logic [5:0]  r_len, n_len;
    logic        r_final, n_final;

    logic             accept;
    logic [CNT_W-1:0] base_pc;
    logic [2:0]       load_stat;
    logic [2:0]       fin_stat;
    logic [CNT_W-1:0] pc_after;
    t_node_code       child1;
    logic [ID_W-1:0]  node_id;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_symbol  = r_osym;
    assign o_code_word   = r_code;
    assign o_code_length = r_len;
    assign o_final_entry = r_final;

    assign base_pc  = r_ready ? '0 : r_pc;
    assign node_id  = ID_W'(NODE_BASE) + ID_W'(r_k);
    assign fin_stat = (r_err != ST_OK) ? r_err : r_lstat;

    // lower-weight child gets the parent code plus a one bit
    assign child1.code = r_nc_rd.code | (32'h8000_0000 >> r_nc_rd.len[4:0]);
    assign child1.len  = r_nc_rd.len + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_ready     = r_ready;
        n_err       = r_err;
        n_lstat     = r_lstat;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_p         = r_p;
        n_k         = r_k;
        n_t         = r_t;
        n_leaf_cnt  = r_leaf_cnt;
        n_ridx      = r_ridx;
        n_e         = r_e;
        n_lo        = r_lo;
        n_sum       = r_sum;
        n_c2_id     = r_c2_id;
        n_c2        = r_c2;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_osym      = r_osym;
        n_code      = r_code;
        n_len       = r_len;
        n_final     = r_final;

        wl_we      = 1'b0;
        wl_waddr   = '0;
        wl_wdata   = '0;
        wl_raddr   = '0;
        tn_we      = 1'b0;
        tn_waddr   = r_k;
        tn_wdata   = '0;
        nc_we      = 1'b0;
        nc_waddr   = '0;
        nc_wdata   = '0;
        leaf_we    = 1'b0;
        leaf_waddr = r_leaf_cnt[IDX_W-1:0];
        leaf_wdata = '0;
        leaf_raddr = i_entry_index[IDX_W-1:0];
        load_stat  = ST_OK;
        pc_after   = base_pc;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_osym  = '0;
                    n_code  = '0;
                    n_len   = '0;
                    n_final = 1'b0;
                    if (i_cmd == CMD_LOAD) begin
                        // a load after a finished build starts a new table
                        n_ready = 1'b0;
                        n_err   = ST_OK;
                        if (i_frequency[FREQ_BITS-1:0] != '0) begin
                            if (base_pc < CNT_W'(MAX_SYMBOLS)) begin
                                wl_we    = 1'b1;
                                wl_waddr = base_pc[IDX_W-1:0];
                                wl_wdata.id     = ID_W'(i_symbol);
                                wl_wdata.weight = WEIGHT_W'(i_frequency[FREQ_BITS-1:0]);
                                pc_after = base_pc + 1'b1;
                            end else begin
                                load_stat = ST_FULL;
                            end
                        end
                        n_pc = pc_after;
                        if (i_last_pair) begin
                            n_ready = 1'b1;
                            if (pc_after < CNT_W'(2)) begin
                                n_err       = ST_TOO_FEW;
                                n_out_valid = 1'b1;
                                n_status    = ST_TOO_FEW;
                            end else begin
                                n_lstat = load_stat;
                                n_i     = CNT_W'(1);
                                n_state = S_SORT_RD;
                            end
                        end else begin
                            n_out_valid = 1'b1;
                            n_status    = load_stat;
                        end
                    end else begin
                        if (!r_ready) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NOT_READY;
                        end else if (r_err != ST_OK) begin
                            n_out_valid = 1'b1;
                            n_status    = r_err;
                        end else if (CNT_W'(i_entry_index) >= r_pc) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NOT_READY;
                        end else begin
                            n_ridx  = i_entry_index[IDX_W-1:0];
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_osym      = r_leaf_rd.sym;
                n_code      = r_leaf_rd.code;
                n_len       = r_leaf_rd.len;
                n_final     = (CNT_W'(r_ridx) + 1'b1) == r_pc;
                n_state     = S_IDLE;
            end
            // stable insertion sort, descending weight
            S_SORT_RD: begin
                wl_raddr = r_i[IDX_W-1:0];
                n_state  = S_SORT_GET;
            end
            S_SORT_GET: begin
                n_e      = r_wl_rd;
                n_j      = r_i;
                wl_raddr = IDX_W'(r_i - 1'b1);
                n_state  = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                wl_we    = 1'b1;
                wl_waddr = r_j[IDX_W-1:0];
                if (r_wl_rd.weight < r_e.weight) begin
                    wl_wdata = r_wl_rd;
                    n_j      = r_j - 1'b1;
                    if (r_j == CNT_W'(1)) begin
                        n_state = S_SORT_PUT;
                    end else begin
                        wl_raddr = IDX_W'(r_j - CNT_W'(2));
                    end
                end else begin
                    wl_wdata = r_e;
                    n_i      = r_i + 1'b1;
                    n_cnt    = r_pc;
                    n_k      = '0;
                    n_state  = ((r_i + 1'b1) == r_pc) ? S_MRG_LO : S_SORT_RD;
                end
            end
            S_SORT_PUT: begin
                wl_we    = 1'b1;
                wl_waddr = '0;
                wl_wdata = r_e;
                n_i      = r_i + 1'b1;
                n_cnt    = r_pc;
                n_k      = '0;
                n_state  = ((r_i + 1'b1) == r_pc) ? S_MRG_LO : S_SORT_RD;
            end
            // merge the two tail entries and insert the new node
            S_MRG_LO: begin
                wl_raddr = IDX_W'(r_cnt - 1'b1);
                n_state  = S_MRG_NX;
            end
            S_MRG_NX: begin
                n_lo     = r_wl_rd;
                wl_raddr = IDX_W'(r_cnt - CNT_W'(2));
                n_state  = S_MRG_SUM;
            end
            S_MRG_SUM: begin
                n_sum          = r_lo.weight + r_wl_rd.weight;
                tn_we          = 1'b1;
                tn_wdata.lo_id = r_lo.id;
                tn_wdata.nx_id = r_wl_rd.id;
                n_cnt          = r_cnt - CNT_W'(2);
                n_p            = '0;
                if (r_cnt == CNT_W'(2)) begin
                    n_j     = '0;
                    n_state = S_MRG_SH;
                end else begin
                    wl_raddr = '0;
                    n_state  = S_MRG_SCAN;
                end
            end
            S_MRG_SCAN: begin
                if (r_wl_rd.weight > r_sum) begin
                    n_p = r_p + 1'b1;
                    if ((r_p + 1'b1) == r_cnt) begin
                        n_j     = r_cnt;
                        n_state = S_MRG_SH;
                    end else begin
                        wl_raddr = IDX_W'(r_p + 1'b1);
                    end
                end else begin
                    n_j     = r_cnt;
                    n_state = S_MRG_SH;
                end
            end
            S_MRG_SH: begin
                if (r_j > r_p) begin
                    wl_raddr = IDX_W'(r_j - 1'b1);
                    n_state  = S_MRG_SH_WR;
                end else begin
                    wl_we           = 1'b1;
                    wl_waddr        = r_p[IDX_W-1:0];
                    wl_wdata.id     = node_id;
                    wl_wdata.weight = r_sum;
                    n_cnt           = r_cnt + 1'b1;
                    n_k             = r_k + 1'b1;
                    n_state = ((CNT_W'(r_k) + CNT_W'(2)) == r_pc) ? S_CODE_INIT : S_MRG_LO;
                end
            end
            S_MRG_SH_WR: begin
                wl_we    = 1'b1;
                wl_waddr = r_j[IDX_W-1:0];
                wl_wdata = r_wl_rd;
                n_j      = r_j - 1'b1;
                n_state  = S_MRG_SH;
            end
            // codes from the root down
            S_CODE_INIT: begin
                nc_we      = 1'b1;
                nc_waddr   = IDX_W'(r_pc - CNT_W'(2));
                nc_wdata   = '0;
                n_t        = IDX_W'(r_pc - CNT_W'(2));
                n_leaf_cnt = '0;
                n_state    = S_CODE_RD;
            end
            S_CODE_RD: begin
                n_state = S_CODE_A;
            end
            S_CODE_A: begin
                if (r_nc_rd.len >= LEN_W'(MAX_BITS)) begin
                    n_err       = ST_TOO_LONG;
                    n_out_valid = 1'b1;
                    n_status    = ST_TOO_LONG;
                    n_state     = S_IDLE;
                end else begin
                    if (r_tn_rd.lo_id[ID_W-1]) begin
                        nc_we    = 1'b1;
                        nc_waddr = r_tn_rd.lo_id[IDX_W-1:0];
                        nc_wdata = child1;
                    end else begin
                        leaf_we         = 1'b1;
                        leaf_wdata.sym  = r_tn_rd.lo_id[SYM_W-1:0];
                        leaf_wdata.code = child1.code;
                        leaf_wdata.len  = child1.len;
                        n_leaf_cnt      = r_leaf_cnt + 1'b1;
                    end
                    n_c2_id     = r_tn_rd.nx_id;
                    n_c2.code   = r_nc_rd.code;
                    n_c2.len    = child1.len;
                    n_state     = S_CODE_B;
                end
            end
            S_CODE_B: begin
                if (r_c2_id[ID_W-1]) begin
                    nc_we    = 1'b1;
                    nc_waddr = r_c2_id[IDX_W-1:0];
                    nc_wdata = r_c2;
                end else begin
                    leaf_we         = 1'b1;
                    leaf_wdata.sym  = r_c2_id[SYM_W-1:0];
                    leaf_wdata.code = r_c2.code;
                    leaf_wdata.len  = r_c2.len;
                    n_leaf_cnt      = r_leaf_cnt + 1'b1;
                end
                if (r_t == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = fin_stat;
                    n_state     = S_IDLE;
                end else begin
                    n_t     = r_t - 1'b1;
                    n_state = S_CODE_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (wl_we) begin
            r_wl_mem[wl_waddr] <= wl_wdata;
        end
        r_wl_rd <= r_wl_mem[wl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tn_we) begin
            r_tn_mem[tn_waddr] <= tn_wdata;
        end
        r_tn_rd <= r_tn_mem[r_t];
    end

    always_ff @(posedge i_clk) begin
        if (nc_we) begin
            r_nc_mem[nc_waddr] <= nc_wdata;
        end
        r_nc_rd <= r_nc_mem[r_t];
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            r_leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        r_leaf_rd <= r_leaf_mem[leaf_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_ready     <= 1'b0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_ready     <= n_ready;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_lstat    <= n_lstat;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cnt      <= n_cnt;
        r_p        <= n_p;
        r_k        <= n_k;
        r_t        <= n_t;
        r_leaf_cnt <= n_leaf_cnt;
        r_ridx     <= n_ridx;
        r_e        <= n_e;
        r_lo       <= n_lo;
        r_sum      <= n_sum;
        r_c2_id    <= n_c2_id;
        r_c2       <= n_c2;
        r_status   <= n_status;
        r_osym     <= n_osym;
        r_code     <= n_code;
        r_len      <= n_len;
        r_final    <= n_final;
    end

    // result slot stays empty while the sequencer is busy
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while sequencer busy");

    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CNT_W'(MAX_SYMBOLS))
        else $error("pair count beyond list size");

    a_err_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> r_ready)
        else $error("build error without a finished build");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_SH || r_state == S_MRG_SH_WR) |-> (r_j >= r_p))
        else $error("shift pointer below insert point");

endmodule
